>>> rtl/hcio_pkg.sv
// shared types and constants of the handheld console i/o register block
`timescale 1ns / 1ps

package hcio_pkg;

	// palette store size in bytes, background half then object half
	localparam int PALETTE_BYTES = 128;
	localparam int PAL_AW = $clog2(PALETTE_BYTES);

	// side-effect command codes
	typedef enum logic [3:0] {
		CMD_NONE        = 4'd0,
		CMD_JOYPAD      = 4'd1,
		CMD_LCD_ON      = 4'd2,
		CMD_LCD_OFF     = 4'd3,
		CMD_OAM_DMA     = 4'd4,
		CMD_HDMA_CANCEL = 4'd5,
		CMD_COPY        = 4'd6,
		CMD_HBLANK      = 4'd7,
		CMD_VRAM_BANK   = 4'd8,
		CMD_WRAM_BANK   = 4'd9,
		CMD_BOOT_OFF    = 4'd10
	} cmd_t;

	// access kinds
	localparam logic FUNC_READ  = 1'b0;
	localparam logic FUNC_WRITE = 1'b1;

	// one bus access
	typedef struct packed {
		logic       func;
		logic [6:0] reg_offset;
		logic [7:0] write_data;
		logic       hdma_busy;
		logic [3:0] button_bits;
		logic [3:0] direction_bits;
		logic [2:0] ppu_status_bits;
	} req_t;

	// one access result
	typedef struct packed {
		logic [7:0]  read_data;
		cmd_t        command;
		logic [15:0] dma_source;
		logic [15:0] dma_dest;
		logic [11:0] dma_length;
		logic [2:0]  bank_value;
	} rsp_t;

endpackage

>>> rtl/hcio_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module hcio_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port, read returns old data on collision
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/handheld_console_io_register_block_unit.sv
// Handheld console i/o register block: takes one bus access per transaction on the req
// channel and returns read data plus at most one side-effect command on the rsp channel.
// One transaction is accepted every cycle while rsp is not stalled; each goes through an
// input register (stage 1, where decode and register update happen) and then a result
// register that drives rsp, where a stalled result is held until it is taken. The palette
// store is a ram read at acceptance time with the index that holds after the transaction
// ahead of it; a write-to-read collision between neighbors is forwarded. Reset clears the
// palette through one valid bit per entry, so no clearing pass is needed and req is taken
// straight out of reset. The color_mode register is written through cfg_wr_en.
`timescale 1ns / 1ps

module handheld_console_io_register_block_unit
	import hcio_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_wr_en,
	input  logic cfg_wr_data,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	// register offsets from 0xff00
	localparam logic [6:0] OFF_P1    = 7'h00;
	localparam logic [6:0] OFF_LCDC  = 7'h40;
	localparam logic [6:0] OFF_STAT  = 7'h41;
	localparam logic [6:0] OFF_DMA   = 7'h46;
	localparam logic [6:0] OFF_KEY1  = 7'h4D;
	localparam logic [6:0] OFF_VBK   = 7'h4F;
	localparam logic [6:0] OFF_BOOT  = 7'h50;
	localparam logic [6:0] OFF_HDMA1 = 7'h51;
	localparam logic [6:0] OFF_HDMA2 = 7'h52;
	localparam logic [6:0] OFF_HDMA3 = 7'h53;
	localparam logic [6:0] OFF_HDMA4 = 7'h54;
	localparam logic [6:0] OFF_HDMA5 = 7'h55;
	localparam logic [6:0] OFF_BGPI  = 7'h68;
	localparam logic [6:0] OFF_BGPD  = 7'h69;
	localparam logic [6:0] OFF_OBPI  = 7'h6A;
	localparam logic [6:0] OFF_OBPD  = 7'h6B;
	localparam logic [6:0] OFF_SVBK  = 7'h70;

	// palette byte address: index low six bits plus half offset, wrapped
	function automatic logic [PAL_AW-1:0] pal_addr(input logic obj, input logic [7:0] idx);
		logic [8:0] sum;
		sum = (obj ? 9'(PALETTE_BYTES / 2) : 9'd0) + {3'b000, idx[5:0]};
		if (sum >= 9'(PALETTE_BYTES)) begin
			sum = sum - 9'(PALETTE_BYTES);
		end
		return sum[PAL_AW-1:0];
	endfunction

	// auto-increment of the palette index when bit7 is set
	function automatic logic [7:0] bump_index(input logic [7:0] idx);
		logic [5:0] low;
		low = idx[5:0] + 6'd1;
		return idx[7] ? {idx[7:6], low} : idx;
	endfunction

	// architectural state
	logic             color_mode_q;
	logic             joy_sel_q;
	logic [7:0]       lcdc_q;
	logic [3:0]       stat_en_q;
	logic [7:0]       oam_dma_q;
	logic             spd_q;
	logic             vbk_q;
	logic [2:0]       svbk_q;
	logic [7:0]       boot_q;
	logic [7:0]       hdma_q [5];
	logic [7:0]       bgpi_q;
	logic [7:0]       obpi_q;
	logic [PALETTE_BYTES-1:0] pal_vld_q;

	// pipeline
	logic             s1_vld_q;
	req_t             req_s1;
	logic             pal_hit_s1;
	logic [7:0]       pal_byp_s1;
	logic             pal_vld_s1;
	logic             rsp_vld_q;
	rsp_t             rsp_q;

	// next-state values computed from the stage 1 transaction
	logic             joy_sel_d;
	logic [7:0]       lcdc_d;
	logic [3:0]       stat_en_d;
	logic [7:0]       oam_dma_d;
	logic             spd_d;
	logic             vbk_d;
	logic [2:0]       svbk_d;
	logic [7:0]       boot_d;
	logic [7:0]       hdma_d [5];
	logic [7:0]       bgpi_d;
	logic [7:0]       obpi_d;
	logic             pal_we;
	logic [PAL_AW-1:0] pal_waddr;
	rsp_t             rsp_d;

	logic             s1_fire;
	logic             req_fire;
	logic             pal_we_fire;
	logic [7:0]       bgpi_nx;
	logic [7:0]       obpi_nx;
	logic             rd_obj;
	logic [PAL_AW-1:0] pal_raddr;
	logic             rd_hit;
	logic [7:0]       ram_rdata;
	logic [7:0]       pal_rd;

	// handshake
	assign s1_fire   = s1_vld_q && (!rsp_vld_q || !rsp_stall);
	assign req_stall = s1_vld_q && !s1_fire;
	assign req_fire  = req_valid && !req_stall;
	assign rsp_valid = rsp_vld_q;
	assign rsp       = rsp_q;

	// palette read address uses the indexes as they stand after stage 1 commits
	assign bgpi_nx     = s1_fire ? bgpi_d : bgpi_q;
	assign obpi_nx     = s1_fire ? obpi_d : obpi_q;
	assign rd_obj      = (req.reg_offset == OFF_OBPD);
	assign pal_raddr   = pal_addr(rd_obj, rd_obj ? obpi_nx : bgpi_nx);
	assign pal_we_fire = s1_fire && pal_we;
	assign rd_hit      = pal_we_fire && (pal_waddr == pal_raddr);

	hcio_ram #(
		.WIDTH(8),
		.DEPTH(PALETTE_BYTES)
	) u_pal_ram (
		.clk  (clk),
		.we   (pal_we_fire),
		.waddr(pal_waddr),
		.wdata(req_s1.write_data),
		.re   (req_fire),
		.raddr(pal_raddr),
		.rdata(ram_rdata)
	);

	// palette data seen by stage 1: forwarded, stored, or reset value
	always_comb begin
		if (pal_hit_s1) begin
			pal_rd = pal_byp_s1;
		end else if (pal_vld_s1) begin
			pal_rd = ram_rdata;
		end else begin
			pal_rd = 8'h00;
		end
	end

	// stage 1 decode and register update
	always_comb begin
		logic [7:0]  v;
		logic [2:0]  bank;
		logic [7:0]  blocks;
		logic [15:0] src;
		logic [15:0] dst;
		v         = req_s1.write_data;
		bank      = (v[2:0] == 3'd0) ? 3'd1 : v[2:0];
		blocks    = {1'b0, v[6:0]} + 8'd1;
		src       = {hdma_q[0], hdma_q[1]} & 16'hFFF0;
		dst       = ({hdma_q[2], hdma_q[3]} & 16'h9FF0) | 16'h8000;
		joy_sel_d = joy_sel_q;
		lcdc_d    = lcdc_q;
		stat_en_d = stat_en_q;
		oam_dma_d = oam_dma_q;
		spd_d     = spd_q;
		vbk_d     = vbk_q;
		svbk_d    = svbk_q;
		boot_d    = boot_q;
		for (int i = 0; i < 5; i++) begin
			hdma_d[i] = hdma_q[i];
		end
		bgpi_d    = bgpi_q;
		obpi_d    = obpi_q;
		pal_we    = 1'b0;
		pal_waddr = pal_addr(req_s1.reg_offset == OFF_OBPD,
			(req_s1.reg_offset == OFF_OBPD) ? obpi_q : bgpi_q);
		rsp_d.read_data  = 8'hFF;
		rsp_d.command    = CMD_NONE;
		rsp_d.dma_source = 16'h0000;
		rsp_d.dma_dest   = 16'h0000;
		rsp_d.dma_length = 12'h000;
		rsp_d.bank_value = 3'd0;

		if (req_s1.func == FUNC_WRITE) begin
			case (req_s1.reg_offset)
				OFF_P1: begin
					if (v[4]) begin
						joy_sel_d = 1'b0;
					end else if (v[5]) begin
						joy_sel_d = 1'b1;
					end
				end
				OFF_LCDC: begin
					lcdc_d = v;
					if (!lcdc_q[7] && v[7]) begin
						rsp_d.command = CMD_LCD_ON;
					end else if (lcdc_q[7] && !v[7]) begin
						rsp_d.command = CMD_LCD_OFF;
					end
				end
				OFF_STAT: stat_en_d = v[6:3];
				OFF_DMA: begin
					oam_dma_d        = v;
					rsp_d.command    = CMD_OAM_DMA;
					rsp_d.dma_source = {v, 8'h00};
				end
				OFF_KEY1: spd_d = v[0];
				OFF_VBK: begin
					vbk_d            = v[0];
					rsp_d.command    = CMD_VRAM_BANK;
					rsp_d.bank_value = {2'b00, v[0]};
				end
				OFF_BOOT: begin
					boot_d = boot_q | v;
					if (v != 8'h00) begin
						rsp_d.command = CMD_BOOT_OFF;
					end
				end
				OFF_HDMA1: if (color_mode_q) hdma_d[0] = v;
				OFF_HDMA2: if (color_mode_q) hdma_d[1] = v & 8'hF0;
				OFF_HDMA3: if (color_mode_q) hdma_d[2] = v;
				OFF_HDMA4: if (color_mode_q) hdma_d[3] = v & 8'hF0;
				OFF_HDMA5: begin
					if (color_mode_q) begin
						if (!v[7] && req_s1.hdma_busy) begin
							rsp_d.command = CMD_HDMA_CANCEL;
							hdma_d[4]     = v;
						end else begin
							rsp_d.command    = v[7] ? CMD_HBLANK : CMD_COPY;
							hdma_d[4]        = v[7] ? v : 8'hFF;
							rsp_d.dma_source = src;
							rsp_d.dma_dest   = dst;
							rsp_d.dma_length = {blocks, 4'b0000};
						end
					end
				end
				OFF_BGPI: bgpi_d = v;
				OFF_BGPD: begin
					pal_we = 1'b1;
					bgpi_d = bump_index(bgpi_q);
				end
				OFF_OBPI: obpi_d = v;
				OFF_OBPD: begin
					pal_we = 1'b1;
					obpi_d = bump_index(obpi_q);
				end
				OFF_SVBK: begin
					svbk_d           = bank;
					rsp_d.command    = CMD_WRAM_BANK;
					rsp_d.bank_value = bank;
				end
				default: begin
				end
			endcase
		end else begin
			case (req_s1.reg_offset)
				OFF_P1: begin
					rsp_d.read_data = joy_sel_q ? {4'hE, req_s1.direction_bits}
						: {4'hD, req_s1.button_bits};
					rsp_d.command   = CMD_JOYPAD;
				end
				OFF_LCDC: rsp_d.read_data = lcdc_q;
				OFF_STAT: rsp_d.read_data = {1'b1, stat_en_q, req_s1.ppu_status_bits};
				OFF_DMA:  rsp_d.read_data = oam_dma_q;
				OFF_KEY1: rsp_d.read_data = color_mode_q ? {7'h3F, spd_q} : 8'hFF;
				OFF_VBK:  rsp_d.read_data = {7'h7F, vbk_q};
				OFF_BOOT: rsp_d.read_data = boot_q;
				OFF_HDMA5: rsp_d.read_data = hdma_q[4];
				OFF_BGPI: rsp_d.read_data = bgpi_q;
				OFF_BGPD: rsp_d.read_data = pal_rd;
				OFF_OBPI: rsp_d.read_data = obpi_q;
				OFF_OBPD: rsp_d.read_data = pal_rd;
				OFF_SVBK: rsp_d.read_data = {5'b00000, svbk_q};
				default: begin
				end
			endcase
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_mode_q <= 1'b1;
		end else if (cfg_wr_en) begin
			color_mode_q <= cfg_wr_data;
		end
	end

	// register state commits when stage 1 moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			joy_sel_q <= 1'b0;
			lcdc_q    <= 8'h00;
			stat_en_q <= 4'h0;
			oam_dma_q <= 8'h00;
			spd_q     <= 1'b0;
			vbk_q     <= 1'b0;
			svbk_q    <= 3'd1;
			boot_q    <= 8'h00;
			for (int i = 0; i < 5; i++) begin
				hdma_q[i] <= 8'h00;
			end
			bgpi_q    <= 8'h00;
			obpi_q    <= 8'h00;
			pal_vld_q <= '0;
		end else if (s1_fire) begin
			joy_sel_q <= joy_sel_d;
			lcdc_q    <= lcdc_d;
			stat_en_q <= stat_en_d;
			oam_dma_q <= oam_dma_d;
			spd_q     <= spd_d;
			vbk_q     <= vbk_d;
			svbk_q    <= svbk_d;
			boot_q    <= boot_d;
			for (int i = 0; i < 5; i++) begin
				hdma_q[i] <= hdma_d[i];
			end
			bgpi_q    <= bgpi_d;
			obpi_q    <= obpi_d;
			if (pal_we) begin
				pal_vld_q[pal_waddr] <= 1'b1;
			end
		end
	end

	// stage 1 valid and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q  <= 1'b0;
			rsp_vld_q <= 1'b0;
		end else begin
			if (req_fire) begin
				s1_vld_q <= 1'b1;
			end else if (s1_fire) begin
				s1_vld_q <= 1'b0;
			end
			if (s1_fire) begin
				rsp_vld_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	// stage 1 payload and palette forwarding
	always_ff @(posedge clk) begin
		if (req_fire) begin
			req_s1     <= req;
			pal_hit_s1 <= rd_hit;
			pal_byp_s1 <= req_s1.write_data;
			pal_vld_s1 <= pal_vld_q[pal_raddr];
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (s1_fire) begin
			rsp_q <= rsp_d;
		end
	end

	// wram bank never reads as zero
	assert property (@(posedge clk) disable iff (!arst_n) svbk_q != 3'd0)
		else $error("wram bank register holds zero");

	// none, hdma cancel and joypad commands carry zero operands
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.command == CMD_NONE || rsp.command == CMD_HDMA_CANCEL ||
		rsp.command == CMD_JOYPAD) |->
		rsp.dma_source == 16'h0000 && rsp.dma_dest == 16'h0000 &&
		rsp.dma_length == 12'h000 && rsp.bank_value == 3'd0)
		else $error("operands set on a command that has none");

	// video memory transfers target video memory with a whole number of blocks
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.command == CMD_COPY || rsp.command == CMD_HBLANK) |->
		rsp.dma_dest[15] && !rsp.dma_dest[14] && rsp.dma_length[3:0] == 4'h0 &&
		rsp.dma_length != 12'h000)
		else $error("malformed hdma transaction");

	// a new transaction enters stage 1 only when stage 1 is empty or moving on
	assert property (@(posedge clk) disable iff (!arst_n)
		req_fire && s1_vld_q |-> s1_fire)
		else $error("stage 1 overwritten");

endmodule

>>> tb/sv/tb_handheld_console_io_register_block_unit.sv
// self-checking testbench of the handheld console i/o register block
`timescale 1ns / 1ps

module tb_handheld_console_io_register_block_unit;
	import hcio_pkg::*;

	// register offsets from 0xFF00
	localparam logic [6:0] OFF_P1    = 7'h00;
	localparam logic [6:0] OFF_LCDC  = 7'h40;
	localparam logic [6:0] OFF_STAT  = 7'h41;
	localparam logic [6:0] OFF_DMA   = 7'h46;
	localparam logic [6:0] OFF_KEY1  = 7'h4D;
	localparam logic [6:0] OFF_VBK   = 7'h4F;
	localparam logic [6:0] OFF_BOOT  = 7'h50;
	localparam logic [6:0] OFF_HDMA1 = 7'h51;
	localparam logic [6:0] OFF_HDMA2 = 7'h52;
	localparam logic [6:0] OFF_HDMA3 = 7'h53;
	localparam logic [6:0] OFF_HDMA4 = 7'h54;
	localparam logic [6:0] OFF_HDMA5 = 7'h55;
	localparam logic [6:0] OFF_BGPI  = 7'h68;
	localparam logic [6:0] OFF_BGPD  = 7'h69;
	localparam logic [6:0] OFF_OBPI  = 7'h6A;
	localparam logic [6:0] OFF_OBPD  = 7'h6B;
	localparam logic [6:0] OFF_SVBK  = 7'h70;
	localparam logic [6:0] OFF_LAST  = 7'h7F;

	localparam int HOLD_CYCLES = 300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic cfg_wr_data = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	// stimulus and expectation stores
	req_t pending_access_q[$];
	rsp_t expected_result_q[$];

	// shared control between the sequence and the driver/monitor
	logic no_gaps = 1'b0;
	int holds_asked = 0;
	int holds_served = 0;
	int hold_left = 0;
	int errors = 0;
	int reports = 0;

	// shadow copy of the register block
	logic       color_on;
	logic       joy_sel;
	logic [7:0] lcdc_r;
	logic [3:0] stat_en;
	logic [7:0] oam_dma_r;
	logic       speed_req;
	logic       vbank;
	logic [2:0] wbank;
	logic [7:0] boot_r;
	logic [7:0] hdma_r [0:4];
	logic [7:0] bgpi_r;
	logic [7:0] obpi_r;
	logic [7:0] palette [0:PALETTE_BYTES-1];

	handheld_console_io_register_block_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp)
	);

	always #5 clk = ~clk;

	// shadow state after reset
	task automatic clear_shadow();
		color_on = 1'b1;
		joy_sel = 1'b0;
		lcdc_r = '0;
		stat_en = '0;
		oam_dma_r = '0;
		speed_req = 1'b0;
		vbank = 1'b0;
		wbank = 3'd1;
		boot_r = '0;
		bgpi_r = '0;
		obpi_r = '0;
		for (int i = 0; i < 5; i++) hdma_r[i] = '0;
		for (int i = 0; i < PALETTE_BYTES; i++) palette[i] = '0;
	endtask

	// palette byte addressed by a base and the low six index bits
	function automatic int pal_slot(input int base, input logic [7:0] idx);
		return (base + int'(idx[5:0])) % PALETTE_BYTES;
	endfunction

	// auto-increment, when bit 7 is set, keeps bits 6-7 and wraps bits 0-5
	function automatic logic [7:0] bumped(input logic [7:0] idx);
		return idx[7] ? {idx[7:6], idx[5:0] + 6'd1} : idx;
	endfunction

	// expected result of one access, updating the shadow state
	function automatic rsp_t predict_access(input req_t a);
		rsp_t r;
		logic [7:0] d;
		logic [2:0] b;
		d = a.write_data;
		r.read_data = 8'hFF;
		r.command = CMD_NONE;
		r.dma_source = '0;
		r.dma_dest = '0;
		r.dma_length = '0;
		r.bank_value = '0;
		if (a.func == FUNC_WRITE) begin
			case (a.reg_offset)
				OFF_P1: begin
					if (d[4]) joy_sel = 1'b0;
					else if (d[5]) joy_sel = 1'b1;
				end
				OFF_LCDC: begin
					if (!lcdc_r[7] && d[7]) r.command = CMD_LCD_ON;
					else if (lcdc_r[7] && !d[7]) r.command = CMD_LCD_OFF;
					lcdc_r = d;
				end
				OFF_STAT: stat_en = d[6:3];
				OFF_DMA: begin
					oam_dma_r = d;
					r.command = CMD_OAM_DMA;
					r.dma_source = {d, 8'h00};
				end
				OFF_KEY1: speed_req = d[0];
				OFF_VBK: begin
					vbank = d[0];
					r.command = CMD_VRAM_BANK;
					r.bank_value = {2'b00, d[0]};
				end
				OFF_BOOT: begin
					if (d != 8'h00) r.command = CMD_BOOT_OFF;
					boot_r = boot_r | d;
				end
				OFF_HDMA1, OFF_HDMA3: begin
					if (color_on) hdma_r[int'(a.reg_offset) - int'(OFF_HDMA1)] = d;
				end
				OFF_HDMA2, OFF_HDMA4: begin
					if (color_on)
						hdma_r[int'(a.reg_offset) - int'(OFF_HDMA1)] = d & 8'hF0;
				end
				OFF_HDMA5: begin
					if (color_on) begin
						if (!d[7] && a.hdma_busy) begin
							r.command = CMD_HDMA_CANCEL;
							hdma_r[4] = d;
						end else begin
							r.command = d[7] ? CMD_HBLANK : CMD_COPY;
							hdma_r[4] = d[7] ? d : 8'hFF;
							r.dma_source = {hdma_r[0], hdma_r[1]} & 16'hFFF0;
							r.dma_dest = ({hdma_r[2], hdma_r[3]} & 16'h9FF0) | 16'h8000;
							r.dma_length = ({5'd0, d[6:0]} + 12'd1) << 4;
						end
					end
				end
				OFF_BGPI: bgpi_r = d;
				OFF_BGPD: begin
					palette[pal_slot(0, bgpi_r)] = d;
					bgpi_r = bumped(bgpi_r);
				end
				OFF_OBPI: obpi_r = d;
				OFF_OBPD: begin
					palette[pal_slot(PALETTE_BYTES / 2, obpi_r)] = d;
					obpi_r = bumped(obpi_r);
				end
				OFF_SVBK: begin
					b = (d[2:0] == 3'd0) ? 3'd1 : d[2:0];
					wbank = b;
					r.command = CMD_WRAM_BANK;
					r.bank_value = b;
				end
				default: ;
			endcase
		end else begin
			case (a.reg_offset)
				OFF_P1: begin
					r.read_data = joy_sel ? {4'hE, a.direction_bits} : {4'hD, a.button_bits};
					r.command = CMD_JOYPAD;
				end
				OFF_LCDC: r.read_data = lcdc_r;
				OFF_STAT: r.read_data = {1'b1, stat_en, a.ppu_status_bits};
				OFF_DMA:  r.read_data = oam_dma_r;
				OFF_KEY1: r.read_data = color_on ? {7'h3F, speed_req} : 8'hFF;
				OFF_VBK:  r.read_data = {7'h7F, vbank};
				OFF_BOOT: r.read_data = boot_r;
				OFF_HDMA5: r.read_data = hdma_r[4];
				OFF_BGPI: r.read_data = bgpi_r;
				OFF_BGPD: r.read_data = palette[pal_slot(0, bgpi_r)];
				OFF_OBPI: r.read_data = obpi_r;
				OFF_OBPD: r.read_data = palette[pal_slot(PALETTE_BYTES / 2, obpi_r)];
				OFF_SVBK: r.read_data = {5'd0, wbank};
				default: ;
			endcase
		end
		return r;
	endfunction

	// random idle cycle, about 36 in a hundred
	function automatic logic take_gap();
		return !no_gaps && ($urandom_range(99) < 36);
	endfunction

	// driver: offers queued accesses and predicts each accepted transaction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
		end else begin
			if (req_valid && !req_stall)
				expected_result_q.push_back(predict_access(req));
			if (!req_valid || !req_stall) begin
				if (pending_access_q.size() != 0 && !take_gap()) begin
					req_valid <= 1'b1;
					req <= pending_access_q.pop_front();
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: random stalls, long hold-offs on request, result checking
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			hold_left <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_result_q.size() == 0) begin
					errors++;
					if (reports < 10) begin
						reports++;
						$display("unexpected result transaction: rd=%h cmd=%0d", rsp.read_data,
							rsp.command);
					end
				end else begin
					rsp_t want;
					want = expected_result_q.pop_front();
					if (rsp.read_data !== want.read_data || rsp.command !== want.command ||
						rsp.dma_source !== want.dma_source || rsp.dma_dest !== want.dma_dest ||
						rsp.dma_length !== want.dma_length ||
						rsp.bank_value !== want.bank_value) begin
						errors++;
						if (reports < 10) begin
							reports++;
							$display("mismatch expected rd=%h cmd=%0d src=%h dst=%h len=%0d bank=%0d",
								want.read_data, want.command, want.dma_source, want.dma_dest,
								want.dma_length, want.bank_value);
							$display("         actual   rd=%h cmd=%0d src=%h dst=%h len=%0d bank=%0d",
								rsp.read_data, rsp.command, rsp.dma_source, rsp.dma_dest,
								rsp.dma_length, rsp.bank_value);
						end
					end
				end
			end
			if (holds_served != holds_asked) begin
				holds_served <= holds_served + 1;
				hold_left <= HOLD_CYCLES;
				rsp_stall <= 1'b1;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= take_gap();
			end
		end
	end

	// queue one access with random side inputs
	task automatic post_access(input logic f, input logic [6:0] off, input logic [7:0] d,
		input logic busy);
		req_t a;
		a.func = f;
		a.reg_offset = off;
		a.write_data = d;
		a.hdma_busy = busy;
		a.button_bits = 4'($urandom);
		a.direction_bits = 4'($urandom);
		a.ppu_status_bits = 3'($urandom);
		pending_access_q.push_back(a);
	endtask

	// mostly mapped registers, sometimes any offset
	function automatic logic [6:0] pick_offset();
		case ($urandom_range(19))
			0: return OFF_P1;
			1: return OFF_LCDC;
			2: return OFF_STAT;
			3: return OFF_DMA;
			4: return OFF_KEY1;
			5: return OFF_VBK;
			6: return OFF_BOOT;
			7: return OFF_HDMA1;
			8: return OFF_HDMA2;
			9: return OFF_HDMA3;
			10: return OFF_HDMA4;
			11: return OFF_HDMA5;
			12: return OFF_BGPI;
			13: return OFF_BGPD;
			14: return OFF_OBPI;
			15: return OFF_OBPD;
			16: return OFF_SVBK;
			default: return 7'($urandom_range(127));
		endcase
	endfunction

	// random traffic: hdma setups, palette bursts, joypad polls and single accesses
	task automatic post_random(input int n);
		int target;
		int burst;
		logic sel;
		logic [7:0] d;
		target = pending_access_q.size() + n;
		while (pending_access_q.size() < target) begin
			case ($urandom_range(9))
				0, 1: begin
					post_access(FUNC_WRITE, OFF_HDMA1, 8'($urandom), 1'($urandom));
					post_access(FUNC_WRITE, OFF_HDMA2, 8'($urandom), 1'($urandom));
					post_access(FUNC_WRITE, OFF_HDMA3, 8'($urandom), 1'($urandom));
					post_access(FUNC_WRITE, OFF_HDMA4, 8'($urandom), 1'($urandom));
					post_access(FUNC_WRITE, OFF_HDMA5, 8'($urandom), 1'($urandom));
					if ($urandom_range(1)) post_access(FUNC_READ, OFF_HDMA5, 8'($urandom), 1'($urandom));
				end
				2, 3: begin
					sel = 1'($urandom);
					d = 8'($urandom);
					if ($urandom_range(3) != 0) d[7] = 1'b1;
					post_access(FUNC_WRITE, sel ? OFF_OBPI : OFF_BGPI, d, 1'($urandom));
					burst = $urandom_range(2, 6);
					for (int i = 0; i < burst; i++)
						post_access(($urandom_range(9) < 7) ? FUNC_WRITE : FUNC_READ,
							sel ? OFF_OBPD : OFF_BGPD, 8'($urandom), 1'($urandom));
				end
				4: begin
					post_access(FUNC_WRITE, OFF_P1, 8'($urandom), 1'($urandom));
					post_access(FUNC_READ, OFF_P1, 8'($urandom), 1'($urandom));
				end
				default: post_access(1'($urandom), pick_offset(), 8'($urandom), 1'($urandom));
			endcase
		end
	endtask

	// sender pause until every transaction has come back
	task automatic drain();
		while (pending_access_q.size() != 0 || req_valid || expected_result_q.size() != 0)
			@(negedge clk);
	endtask

	// color mode write while the block is idle
	task automatic write_color_mode(input logic v);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		color_on = v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// test sequence
	initial begin
		clear_shadow();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		write_color_mode(1'b1);

		// directed: joypad select, lcd edges, bank rules, hdma modes, palette wrap
		post_access(FUNC_READ, OFF_P1, 8'h00, 1'b0);
		post_access(FUNC_WRITE, OFF_P1, 8'h20, 1'b0);
		post_access(FUNC_READ, OFF_P1, 8'hFF, 1'b1);
		post_access(FUNC_WRITE, OFF_P1, 8'hCF, 1'b0);
		post_access(FUNC_WRITE, OFF_P1, 8'hFF, 1'b0);
		post_access(FUNC_WRITE, OFF_LCDC, 8'hFF, 1'b0);
		post_access(FUNC_WRITE, OFF_LCDC, 8'h7F, 1'b0);
		post_access(FUNC_WRITE, OFF_STAT, 8'hFF, 1'b0);
		post_access(FUNC_READ, OFF_STAT, 8'h00, 1'b0);
		post_access(FUNC_WRITE, OFF_DMA, 8'hFF, 1'b0);
		post_access(FUNC_WRITE, OFF_KEY1, 8'hFF, 1'b0);
		post_access(FUNC_READ, OFF_KEY1, 8'h00, 1'b0);
		post_access(FUNC_WRITE, OFF_VBK, 8'hFF, 1'b0);
		post_access(FUNC_WRITE, OFF_BOOT, 8'h00, 1'b0);
		post_access(FUNC_WRITE, OFF_BOOT, 8'h01, 1'b0);
		post_access(FUNC_WRITE, OFF_SVBK, 8'hF8, 1'b0);
		post_access(FUNC_READ, OFF_SVBK, 8'h00, 1'b0);
		post_access(FUNC_WRITE, OFF_HDMA1, 8'hFF, 1'b0);
		post_access(FUNC_WRITE, OFF_HDMA2, 8'hFF, 1'b0);
		post_access(FUNC_WRITE, OFF_HDMA3, 8'hFF, 1'b0);
		post_access(FUNC_WRITE, OFF_HDMA4, 8'hFF, 1'b0);
		post_access(FUNC_WRITE, OFF_HDMA5, 8'h00, 1'b1);
		post_access(FUNC_WRITE, OFF_HDMA5, 8'h7F, 1'b0);
		post_access(FUNC_WRITE, OFF_HDMA5, 8'h80, 1'b1);
		post_access(FUNC_READ, OFF_HDMA5, 8'h00, 1'b0);
		post_access(FUNC_WRITE, OFF_BGPI, 8'hBF, 1'b0);
		post_access(FUNC_WRITE, OFF_BGPD, 8'hAA, 1'b0);
		post_access(FUNC_READ, OFF_BGPI, 8'h00, 1'b0);
		post_access(FUNC_WRITE, OFF_OBPI, 8'h7F, 1'b0);
		post_access(FUNC_WRITE, OFF_OBPD, 8'h55, 1'b0);
		post_access(FUNC_READ, OFF_OBPD, 8'h00, 1'b0);
		post_access(FUNC_WRITE, OFF_LAST, 8'hFF, 1'b0);
		post_access(FUNC_READ, OFF_LAST, 8'h00, 1'b0);
		drain();

		// color mode off: hdma writes dropped, key1 reads 0xff
		write_color_mode(1'b0);
		post_random(120);
		drain();

		// back-to-back stretch with no idling on either side
		write_color_mode(1'b1);
		no_gaps = 1'b1;
		post_random(130);
		drain();
		no_gaps = 1'b0;

		// long receiver hold-off while the sender keeps offering
		post_random(130);
		holds_asked = holds_asked + 1;
		drain();

		write_color_mode(1'b0);
		post_random(40);
		drain();
		write_color_mode(1'b1);
		post_random(60);
		drain();

		repeat (10) @(posedge clk);
		if (errors == 0 && expected_result_q.size() == 0) begin
			$display("tb_handheld_console_io_register_block_unit passed");
		end else begin
			$display("tb_handheld_console_io_register_block_unit failed");
		end
		$finish;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("tb_handheld_console_io_register_block_unit failed");
		$finish;
	end

endmodule

>>> sim.f
rtl/hcio_pkg.sv
rtl/hcio_ram.sv
rtl/handheld_console_io_register_block_unit.sv
tb/sv/tb_handheld_console_io_register_block_unit.sv
